// ----- hw/rtl/xmir_pkg.sv -----
// Package: shared types and constants for the XMODEM image receiver.
`timescale 1ns / 1ps
package xmir_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_EOT   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_NAK   = 3'd0,
    K_ACK   = 3'd1,
    K_STORE = 3'd2,
    K_DONE  = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    E_NO_SOH  = 3'd0,
    E_BLOCK   = 3'd1,
    E_HEADER  = 3'd2,
    E_TYPE    = 3'd3,
    E_TOO_BIG = 3'd4,
    E_NO_EOT  = 3'd5,
    E_TIMEOUT = 3'd6
  } cause_t;

  typedef enum logic [2:0] {
    CFG_VERSION   = 3'd0,
    CFG_APP_LIM   = 3'd1,
    CFG_FPGA_LIM  = 3'd2,
    CFG_DEV_LIM   = 3'd3,
    CFG_PROJ_LIM  = 3'd4,
    CFG_NAK_INT   = 3'd5,
    CFG_QUIET_TMO = 3'd6
  } cfg_idx_t;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] HDR_MARK0 = 8'h01;
  localparam logic [7:0] HDR_MARK1 = 8'hA0;
  localparam logic [15:0] TYPE_APP  = 16'h0001;
  localparam logic [15:0] TYPE_FPGA = 16'h0002;
  localparam logic [15:0] TYPE_DEV  = 16'h0010;
  localparam logic [15:0] TYPE_PROJ = 16'h0011;
  localparam logic [7:0] LAST_DATA_POS = 8'd130;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0]  version;
    logic [21:0] app_lim;
    logic [21:0] fpga_lim;
    logic [21:0] dev_lim;
    logic [21:0] proj_lim;
    logic [15:0] nak_int;
    logic [15:0] quiet_tmo;
  } cfg_t;

endpackage

// ----- hw/rtl/xmodem_image_receiver_core.sv -----
// Top level: XMODEM image receiver core with stream input and result channels.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_*): one transfer per received UART byte or per
//   millisecond tick. tuser is the opcode (1 = tick), tdata the byte.
//   Result channel (out_*): at most one result per input transfer: NAK, ACK,
//   store byte (address, data, region), ACK-and-done (region, image length)
//   or error (cause).
//   Configuration: write-only register port (cfg_we, cfg_addr, cfg_wdata),
//   to be written only while the block is idle.
// Timing:
//   An input transfer is absorbed by a registered state update; its result is
//   held in the output register from the next cycle. One item is accepted
//   every cycle unless a result stalls in the output register; the only loop
//   is the protocol state update.
// Reset: synchronous active-low rst_n clears protocol state to idle, block
//   number one, and loads configuration defaults; the output is empty.
// Stall: while a result waits in the output register with out_tready low,
//   in_tready drops; items that produce no result are still blocked then.
module xmodem_image_receiver_core #(
  parameter int HEADER_BYTES    = 32,
  parameter int STORE_ADDR_BITS = 21
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] kind, [2+SAB:3] store_addr, next 8 store_data, next 2 region,
  // next 22 image_length, next 3 error_cause, zero fill to bytes
  output logic [((38 + STORE_ADDR_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [21:0] cfg_wdata
);
  import xmir_pkg::*;

  localparam int HB = HEADER_BYTES;
  localparam int SAB = STORE_ADDR_BITS;
  localparam int OW = ((38 + SAB + 7) / 8) * 8;
  localparam int PW = 38 + SAB;
  localparam logic [7:0] HDR_LEN_BYTE = 8'(HB / 4);
  localparam logic [21:0] HB22 = 22'(HB);

  cfg_t cfg;

  xmir_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .cfg
  );

  // Protocol state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  fpos_r, fpos_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [21:0] rcnt_r, rcnt_nxt;
  logic [32:0] total_r, total_nxt;
  logic [15:0] htype_r, htype_nxt;
  logic        hgood_r, hgood_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic [1:0]  region_r, region_nxt;

  // Output register
  logic          ovalid_r;
  logic [PW-1:0] odata_r;

  logic         emit;
  kind_t        kind;
  logic [SAB-1:0] saddr;
  logic [7:0]   sdata;
  logic [1:0]   oreg;
  logic [21:0]  olen;
  cause_t       cause;

  logic accept;
  assign in_tready = !ovalid_r || out_tready;
  assign accept = in_tvalid && in_tready;

  logic [15:0] quiet_inc;
  logic [7:0]  b;
  logic [21:0] lim;
  logic [32:0] tot_hdr;
  logic        hg;
  assign b = in_tdata;
  assign quiet_inc = (quiet_r == 16'hFFFF) ? quiet_r : quiet_r + 16'd1;

  // Next state and result for one input item
  always_comb begin
    phase_nxt = phase_r; fpos_nxt = fpos_r; blk_nxt = blk_r;
    rcnt_nxt = rcnt_r; total_nxt = total_r; htype_nxt = htype_r;
    hgood_nxt = hgood_r; quiet_nxt = quiet_r; region_nxt = region_r;
    emit = 1'b0; kind = K_NAK; saddr = '0; sdata = '0; oreg = '0;
    olen = '0; cause = E_NO_SOH;
    lim = cfg.app_lim; tot_hdr = '0; hg = hgood_r;
    if (in_tuser) begin
      quiet_nxt = quiet_inc;
      if (phase_r == PH_IDLE) begin
        if (quiet_inc >= cfg.nak_int) begin
          quiet_nxt = '0; emit = 1'b1; kind = K_NAK;
        end
      end else if (quiet_inc >= cfg.quiet_tmo) begin
        emit = 1'b1; kind = K_ERROR; cause = E_TIMEOUT;
      end
    end else begin
      quiet_nxt = '0;
      case (phase_r)
        PH_IDLE: begin
          if (b != B_SOH) begin
            emit = 1'b1; kind = K_ERROR; cause = E_NO_SOH;
          end else begin
            phase_nxt = PH_FRAME; fpos_nxt = 8'd1; blk_nxt = 8'd1;
            rcnt_nxt = '0; total_nxt = '0; htype_nxt = '0;
            hgood_nxt = 1'b1; region_nxt = '0;
          end
        end
        PH_EOT: begin
          emit = 1'b1;
          if (b != B_EOT) begin
            kind = K_ERROR; cause = E_NO_EOT;
          end else begin
            kind = K_DONE; oreg = region_r;
            olen = total_r[21:0] - HB22;
          end
        end
        default: begin
          fpos_nxt = fpos_r + 8'd1;
          if (fpos_r == 8'd0) begin
            if (b != B_SOH) begin
              emit = 1'b1; kind = K_ERROR; cause = E_NO_SOH;
            end
          end else if (fpos_r == 8'd1) begin
            if (b != blk_r) begin
              emit = 1'b1; kind = K_ERROR; cause = E_BLOCK;
            end
          end else if (fpos_r == 8'd2) begin
            if (b != ~blk_r) begin
              emit = 1'b1; kind = K_ERROR; cause = E_BLOCK;
            end
          end else if (fpos_r <= LAST_DATA_POS) begin
            if (rcnt_r < HB22) begin
              // Header byte
              emit = 1'b1; kind = K_STORE;
              if (rcnt_r < 22'd4) begin
                total_nxt = total_r | (33'(b) << {rcnt_r[1:0], 3'b000});
              end else if (rcnt_r == 22'd4) begin
                hg = hg && (b == HDR_LEN_BYTE);
              end else if (rcnt_r == 22'd5) begin
                hg = hg && (b == cfg.version);
              end else if (rcnt_r == 22'd6) begin
                htype_nxt = {8'd0, b};
              end else if (rcnt_r == 22'd7) begin
                htype_nxt = {b, htype_r[7:0]};
              end
              if (rcnt_r == HB22 - 22'd2) hg = hg && (b == HDR_MARK0);
              hgood_nxt = hg;
              if (rcnt_r == HB22 - 22'd1) begin
                hg = hg && (b == HDR_MARK1);
                hgood_nxt = hg;
                tot_hdr = total_r + 33'(HB);
                case (htype_r)
                  TYPE_APP:  begin region_nxt = 2'd0; lim = cfg.app_lim; end
                  TYPE_FPGA: begin region_nxt = 2'd1; lim = cfg.fpga_lim; end
                  TYPE_DEV:  begin region_nxt = 2'd2; lim = cfg.dev_lim; end
                  TYPE_PROJ: begin region_nxt = 2'd3; lim = cfg.proj_lim; end
                  default:   region_nxt = region_r;
                endcase
                total_nxt = tot_hdr;
                if (!hg) begin
                  kind = K_ERROR; cause = E_HEADER;
                end else if (!(htype_r == TYPE_APP || htype_r == TYPE_FPGA ||
                               htype_r == TYPE_DEV || htype_r == TYPE_PROJ)) begin
                  kind = K_ERROR; cause = E_TYPE;
                end else if (tot_hdr > 33'(lim)) begin
                  kind = K_ERROR; cause = E_TOO_BIG;
                end
              end
              if (kind == K_STORE) begin
                rcnt_nxt = rcnt_r + 22'd1;
                saddr = SAB'(rcnt_r); sdata = b; oreg = region_nxt;
              end
            end else if (33'(rcnt_r) < total_r) begin
              emit = 1'b1; kind = K_STORE;
              rcnt_nxt = rcnt_r + 22'd1;
              saddr = SAB'(rcnt_r); sdata = b; oreg = region_r;
            end
          end else begin
            // Checksum byte ends the block
            fpos_nxt = '0;
            blk_nxt = blk_r + 8'd1;
            if (33'(rcnt_r) >= total_r) phase_nxt = PH_EOT;
            emit = 1'b1; kind = K_ACK;
          end
        end
      endcase
    end
    // Done and errors go back to idle
    if (emit && (kind == K_ERROR || kind == K_DONE)) begin
      phase_nxt = PH_IDLE; fpos_nxt = '0; blk_nxt = 8'd1; quiet_nxt = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; fpos_r <= '0; blk_r <= 8'd1; rcnt_r <= '0;
      total_r <= '0; htype_r <= '0; hgood_r <= 1'b1; quiet_r <= '0;
      region_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt; fpos_r <= fpos_nxt; blk_r <= blk_nxt;
      rcnt_r <= rcnt_nxt; total_r <= total_nxt; htype_r <= htype_nxt;
      hgood_r <= hgood_nxt; quiet_r <= quiet_nxt; region_r <= region_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (in_tready) begin
      ovalid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      odata_r <= {(kind == K_ERROR) ? cause : E_NO_SOH, olen, oreg, sdata, saddr, kind};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = OW'(odata_r);

endmodule

// ----- hw/rtl/xmir_cfg_regs.sv -----
// Configuration register file for the XMODEM image receiver.
`timescale 1ns / 1ps
module xmir_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [21:0]         cfg_wdata,
  output xmir_pkg::cfg_t      cfg
);
  import xmir_pkg::*;

  cfg_t cfg_r;

  // Register writes, reset to documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version   <= 8'd1;
      cfg_r.app_lim   <= 22'd1048576;
      cfg_r.fpga_lim  <= 22'd1048576;
      cfg_r.dev_lim   <= 22'd65536;
      cfg_r.proj_lim  <= 22'd65536;
      cfg_r.nak_int   <= 16'd2000;
      cfg_r.quiet_tmo <= 16'd60000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VERSION:   cfg_r.version   <= cfg_wdata[7:0];
        CFG_APP_LIM:   cfg_r.app_lim   <= cfg_wdata;
        CFG_FPGA_LIM:  cfg_r.fpga_lim  <= cfg_wdata;
        CFG_DEV_LIM:   cfg_r.dev_lim   <= cfg_wdata;
        CFG_PROJ_LIM:  cfg_r.proj_lim  <= cfg_wdata;
        CFG_NAK_INT:   cfg_r.nak_int   <= cfg_wdata[15:0];
        CFG_QUIET_TMO: cfg_r.quiet_tmo <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/xmir_checker.sv -----
// Port-level checker for the XMODEM image receiver core, with its bind.
`timescale 1ns / 1ps
module xmir_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [2:0] out_kind
);
  import xmir_pkg::*;

  // A waiting result is held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Input blocked only while a stalled result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without cause");

  // A result appears only after an input transfer
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without input");

  // Result kind is a defined code
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_kind <= K_ERROR)
    else $error("bad result kind");

endmodule

bind xmodem_image_receiver_core xmir_checker u_xmir_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_kind(out_tdata[2:0])
);
